// ----- hw/rtl/rtcc_pkg.sv -----
`default_nettype none
package rtcc_pkg;

  // request kinds carried in the input tuser bit
  localparam logic REQ_TICK = 1'b0;
  localparam logic REQ_SET  = 1'b1;

  localparam logic [15:0] TPS_RESET  = 16'd1000;

  localparam logic [5:0]  SEC_MAX    = 6'd59;
  localparam logic [5:0]  MIN_MAX    = 6'd59;
  localparam logic [3:0]  HOUR_MIN   = 4'd1;
  localparam logic [3:0]  HOUR_MAX   = 4'd12;
  localparam logic [2:0]  WDAY_MIN   = 3'd1;
  localparam logic [2:0]  WDAY_MAX   = 3'd7;
  localparam logic [4:0]  DATE_MIN   = 5'd1;
  localparam logic [3:0]  MONTH_MIN  = 4'd1;
  localparam logic [3:0]  MONTH_MAX  = 4'd12;
  localparam logic [13:0] YEAR_MAX   = 14'd9999;

  localparam logic [5:0]  SEC_RESET   = 6'd10;
  localparam logic [5:0]  MIN_RESET   = 6'd10;
  localparam logic [3:0]  HOUR_RESET  = 4'd10;
  localparam logic        AM_RESET    = 1'b1;
  localparam logic [2:0]  WDAY_RESET  = 3'd1;
  localparam logic [4:0]  DATE_RESET  = 5'd1;
  localparam logic [3:0]  MONTH_RESET = 4'd1;
  localparam logic [13:0] YEAR_RESET  = 14'd2000;

  // reciprocal of 100 scaled by 2^19, exact for every 14-bit year
  localparam logic [26:0] RECIP_100 = 27'd5243;
  localparam int          RECIP_SH  = 19;

  typedef struct packed {
    logic        req_type;
    logic [3:0]  set_hour;
    logic [5:0]  set_minute;
    logic [5:0]  set_second;
    logic        set_is_am;
    logic [2:0]  set_weekday;
    logic [4:0]  set_date;
    logic [3:0]  set_month;
    logic [13:0] set_year;
  } item_t;

  // meridiem event from the time-of-day unit to the calendar
  typedef struct packed {
    logic flip;
    logic am;
  } mer_t;

  function automatic logic is_leap(input logic [13:0] y);
    logic [26:0] prod;
    logic [7:0]  cent;
    logic [13:0] cent_x100;
    logic        whole_cent;
    prod       = {13'd0, y} * RECIP_100;
    cent       = prod[26:RECIP_SH];
    cent_x100  = {cent, 6'd0} + {1'b0, cent, 5'd0} + {4'd0, cent, 2'd0};
    whole_cent = (cent_x100 == y);
    return (y[1:0] == 2'd0) && (!whole_cent || (cent[1:0] == 2'd0));
  endfunction

  function automatic logic [4:0] month_len(input logic [3:0] m, input logic [13:0] y);
    logic [4:0] len;
    case (m) inside
      4'd1, 4'd3, 4'd5, 4'd7, 4'd8, 4'd10, 4'd12: len = 5'd31;
      4'd4, 4'd6, 4'd9, 4'd11:                    len = 5'd30;
      default:                                    len = is_leap(y) ? 5'd29 : 5'd28;
    endcase
    return len;
  endfunction

endpackage
`default_nettype wire

// ----- hw/rtl/rtcc_in_stage.sv -----
`default_nettype none
module rtcc_in_stage (
  input  wire logic            clk,
  input  wire logic            rst_n,
  input  wire logic            in_valid,
  output logic                 in_ready,
  input  wire rtcc_pkg::item_t in_item,
  input  wire logic            out_busy,
  output logic                 adv,
  output rtcc_pkg::item_t      item
);
  import rtcc_pkg::*;

  logic  stg_valid_r;
  logic  stg_valid_nxt;
  item_t stg_item_r;

  // item leaves when the result register is free or being drained
  assign adv      = stg_valid_r && !out_busy;
  assign in_ready = !stg_valid_r || adv;
  assign item     = stg_item_r;

  always_comb begin
    stg_valid_nxt = stg_valid_r;
    if (in_valid && in_ready) begin
      stg_valid_nxt = 1'b1;
    end else if (adv) begin
      stg_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      stg_valid_r <= 1'b0;
    end else begin
      stg_valid_r <= stg_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      stg_item_r <= in_item;
    end
  end

endmodule
`default_nettype wire

// ----- hw/rtl/rtcc_clock.sv -----
`default_nettype none
module rtcc_clock (
  input  wire logic            clk,
  input  wire logic            rst_n,
  input  wire logic            adv,
  input  wire rtcc_pkg::item_t item,
  input  wire logic [15:0]     tps,
  output logic [3:0]           hour,
  output logic [5:0]           minute,
  output logic [5:0]           second,
  output logic                 is_am,
  output logic                 colon_on,
  output rtcc_pkg::mer_t       mer
);
  import rtcc_pkg::*;

  logic [15:0] tick_r, tick_nxt;
  logic [5:0]  sec_r, sec_nxt;
  logic [5:0]  min_r, min_nxt;
  logic [3:0]  hour_r, hour_nxt;
  logic        am_r, am_nxt;
  logic        blink_r, blink_nxt;

  logic [16:0] tick_inc;
  logic        sec_hit;
  logic [6:0]  sec_inc;
  logic        sec_wrap;
  logic [6:0]  min_inc;
  logic        min_wrap;
  logic [4:0]  hour_inc;
  logic [3:0]  hour_adv;
  logic        flip;

  always_comb begin
    tick_inc = {1'b0, tick_r} + 17'd1;
    sec_hit  = tick_inc >= {1'b0, tps};
    sec_inc  = {1'b0, sec_r} + {6'd0, sec_hit};
    // an out-of-range second wraps on any tick, even without a second step
    sec_wrap = sec_inc > {1'b0, SEC_MAX};
    min_inc  = {1'b0, min_r} + 7'd1;
    min_wrap = sec_wrap && (min_inc > {1'b0, MIN_MAX});
    hour_inc = {1'b0, hour_r} + 5'd1;
    hour_adv = (hour_inc > {1'b0, HOUR_MAX}) ? HOUR_MIN : hour_inc[3:0];
    flip     = min_wrap && (hour_adv == HOUR_MAX);

    tick_nxt  = tick_r;
    sec_nxt   = sec_r;
    min_nxt   = min_r;
    hour_nxt  = hour_r;
    am_nxt    = am_r;
    blink_nxt = blink_r;
    if (adv) begin
      if (item.req_type == REQ_SET) begin
        tick_nxt = '0;
        sec_nxt  = item.set_second;
        min_nxt  = item.set_minute;
        hour_nxt = item.set_hour;
        am_nxt   = item.set_is_am;
      end else begin
        tick_nxt  = sec_hit ? '0 : tick_inc[15:0];
        blink_nxt = blink_r ^ sec_hit;
        sec_nxt   = sec_wrap ? '0 : sec_inc[5:0];
        if (sec_wrap) begin
          min_nxt = min_wrap ? '0 : min_inc[5:0];
        end
        if (min_wrap) begin
          hour_nxt = hour_adv;
        end
        if (flip) begin
          am_nxt = ~am_r;
        end
      end
    end
    mer.flip = adv && (item.req_type == REQ_TICK) && flip;
    mer.am   = am_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tick_r  <= '0;
      sec_r   <= SEC_RESET;
      min_r   <= MIN_RESET;
      hour_r  <= HOUR_RESET;
      am_r    <= AM_RESET;
      blink_r <= 1'b0;
    end else begin
      tick_r  <= tick_nxt;
      sec_r   <= sec_nxt;
      min_r   <= min_nxt;
      hour_r  <= hour_nxt;
      am_r    <= am_nxt;
      blink_r <= blink_nxt;
    end
  end

  assign hour     = hour_r;
  assign minute   = min_r;
  assign second   = sec_r;
  assign is_am    = am_r;
  assign colon_on = blink_r;

endmodule
`default_nettype wire

// ----- hw/rtl/rtcc_calendar.sv -----
`default_nettype none
module rtcc_calendar (
  input  wire logic            clk,
  input  wire logic            rst_n,
  input  wire logic            adv,
  input  wire rtcc_pkg::item_t item,
  input  wire rtcc_pkg::mer_t  mer,
  output logic [2:0]           weekday,
  output logic [4:0]           day_of_month,
  output logic [3:0]           month_now,
  output logic [13:0]          year_now
);
  import rtcc_pkg::*;

  logic [2:0]  wday_r, wday_nxt;
  logic [4:0]  date_r, date_nxt;
  logic [3:0]  month_r, month_nxt;
  logic [13:0] year_r, year_nxt;

  logic [5:0]  date_inc;
  logic [3:0]  wday_inc;
  logic        date_wrap;
  logic [4:0]  month_inc;
  logic        month_wrap;
  logic [14:0] year_inc;
  logic [4:0]  set_len;

  always_comb begin
    // date and weekday step only on the flip into am, the rollover checks run on both flips
    date_inc   = {1'b0, date_r} + {5'd0, mer.am};
    wday_inc   = {1'b0, wday_r} + {3'd0, mer.am};
    date_wrap  = date_inc > {1'b0, month_len(month_r, year_r)};
    month_inc  = {1'b0, month_r} + {4'd0, date_wrap};
    month_wrap = month_inc > {1'b0, MONTH_MAX};
    year_inc   = {1'b0, year_r} + 15'd1;
    set_len    = month_len(item.set_month, item.set_year);

    wday_nxt  = wday_r;
    date_nxt  = date_r;
    month_nxt = month_r;
    year_nxt  = year_r;
    if (adv && (item.req_type == REQ_SET)) begin
      wday_nxt  = item.set_weekday;
      date_nxt  = (item.set_date > set_len) ? DATE_MIN : item.set_date;
      month_nxt = item.set_month;
      year_nxt  = item.set_year;
    end else if (mer.flip) begin
      wday_nxt  = (wday_inc > {1'b0, WDAY_MAX}) ? WDAY_MIN : wday_inc[2:0];
      date_nxt  = date_wrap ? DATE_MIN : date_inc[4:0];
      month_nxt = month_wrap ? MONTH_MIN : month_inc[3:0];
      if (month_wrap) begin
        year_nxt = (year_inc > {1'b0, YEAR_MAX}) ? '0 : year_inc[13:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wday_r  <= WDAY_RESET;
      date_r  <= DATE_RESET;
      month_r <= MONTH_RESET;
      year_r  <= YEAR_RESET;
    end else begin
      wday_r  <= wday_nxt;
      date_r  <= date_nxt;
      month_r <= month_nxt;
      year_r  <= year_nxt;
    end
  end

  assign weekday      = wday_r;
  assign day_of_month = date_r;
  assign month_now    = month_r;
  assign year_now     = year_r;

endmodule
`default_nettype wire

// ----- hw/rtl/rtc_calendar_12h_core.sv -----
`default_nettype none
// 12-hour real-time clock and calendar driven by a stream of request beats. A tick beat
// (in_tuser = 0) counts one tick; after cfg ticks-per-second ticks the second advances and
// the colon bit toggles, with carries through minute, hour (1..12), am/pm, weekday, date
// (month lengths with gregorian leap years), month and year (wraps 9999 -> 0). A set beat
// (in_tuser = 1) loads every field, clears the tick count and forces an oversized date to
// 1; the colon bit is kept. Every request gives exactly one result beat carrying the clock
// state after that request. Throughput is one beat per clock unless the output stalls:
// an input register feeds the clock and calendar registers, which double as the result
// register, so each beat passes the input register, then the state registers. The input
// register holds one further beat while a result is stalled on the output, then in_tready
// drops. Write cfg only while no request is in flight.
module rtc_calendar_12h_core (
  input  wire logic        clk,
  input  wire logic        rst_n,
  // configuration: ticks per second
  input  wire logic        cfg_we,
  input  wire logic [15:0] cfg_wdata,
  // request stream
  input  wire logic        in_tvalid,
  output logic             in_tready,
  // tdata: set_hour[3:0] set_minute[9:4] set_second[15:10] set_is_am[16]
  //        set_weekday[19:17] set_date[24:20] set_month[28:25] set_year[42:29]
  input  wire logic [47:0] in_tdata,
  // tuser: req_type (0 = tick, 1 = set)
  input  wire logic        in_tuser,
  // result stream
  output logic             out_tvalid,
  input  wire logic        out_tready,
  // tdata: hour[3:0] minute[9:4] second[15:10] is_am[16] weekday[19:17]
  //        day_of_month[24:20] month_now[28:25] year_now[42:29] colon_on[43]
  output logic [47:0]      out_tdata
);
  import rtcc_pkg::*;

  logic [15:0] tps_r;
  logic        out_valid_r, out_valid_nxt;

  item_t       in_item;
  item_t       item;
  logic        adv;
  logic        out_busy;
  mer_t        mer;

  logic [3:0]  hour;
  logic [5:0]  minute;
  logic [5:0]  second;
  logic        is_am;
  logic        colon_on;
  logic [2:0]  weekday;
  logic [4:0]  day_of_month;
  logic [3:0]  month_now;
  logic [13:0] year_now;

  // ticks-per-second register, no read-back
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tps_r <= TPS_RESET;
    end else if (cfg_we) begin
      tps_r <= cfg_wdata;
    end
  end

  // unpack the request beat
  always_comb begin
    in_item.req_type    = in_tuser;
    in_item.set_hour    = in_tdata[3:0];
    in_item.set_minute  = in_tdata[9:4];
    in_item.set_second  = in_tdata[15:10];
    in_item.set_is_am   = in_tdata[16];
    in_item.set_weekday = in_tdata[19:17];
    in_item.set_date    = in_tdata[24:20];
    in_item.set_month   = in_tdata[28:25];
    in_item.set_year    = in_tdata[42:29];
  end

  // the state registers are the result, so they only move when the result slot frees up
  assign out_busy = out_valid_r && !out_tready;

  rtcc_in_stage u_in_stage (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_tvalid),
    .in_ready (in_tready),
    .in_item  (in_item),
    .out_busy (out_busy),
    .adv      (adv),
    .item     (item)
  );

  // time of day, tick counter and colon blink
  rtcc_clock u_clock (
    .clk      (clk),
    .rst_n    (rst_n),
    .adv      (adv),
    .item     (item),
    .tps      (tps_r),
    .hour     (hour),
    .minute   (minute),
    .second   (second),
    .is_am    (is_am),
    .colon_on (colon_on),
    .mer      (mer)
  );

  // weekday, date, month, year; loads on a set, steps on the am/pm flip
  rtcc_calendar u_calendar (
    .clk          (clk),
    .rst_n        (rst_n),
    .adv          (adv),
    .item         (item),
    .mer          (mer),
    .weekday      (weekday),
    .day_of_month (day_of_month),
    .month_now    (month_now),
    .year_now     (year_now)
  );

  // result valid: set when a request lands, cleared when taken
  always_comb begin
    out_valid_nxt = out_valid_r;
    if (adv) begin
      out_valid_nxt = 1'b1;
    end else if (out_tready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {4'd0, colon_on, year_now, month_now, day_of_month, weekday,
                       is_am, second, minute, hour};

  // a tick always leaves the second in range
  a_sec_range: assert property (@(posedge clk) disable iff (!rst_n)
    (adv && (item.req_type == REQ_TICK)) |=> (out_tdata[15:10] <= SEC_MAX))
    else $error("second out of range after tick");

  // the state must not move while a result is held on a stalled output
  a_hold_stall: assert property (@(posedge clk) disable iff (!rst_n)
    out_busy |=> $stable(out_tdata))
    else $error("result changed while stalled");

  // colon bit only changes on a processed tick
  a_colon: assert property (@(posedge clk) disable iff (!rst_n)
    !(adv && (item.req_type == REQ_TICK)) |=> $stable(colon_on))
    else $error("colon toggled without a tick");

  // calendar only changes on a set or an am/pm flip
  a_cal: assert property (@(posedge clk) disable iff (!rst_n)
    (!mer.flip && !(adv && (item.req_type == REQ_SET))) |=> $stable(out_tdata[42:17]))
    else $error("calendar changed without flip or set");

endmodule
`default_nettype wire

// ----- tb/sv/tb_rtc_calendar_12h_core.sv -----
`timescale 1ns / 100ps
module tb_rtc_calendar_12h_core;
  import rtcc_pkg::*;

  // run limit, long receiver hold-off, settle time before cfg writes and at the end
  localparam int unsigned CYCLE_LIMIT   = 500000;
  localparam int unsigned HOLD_CYCLES   = 300;
  localparam int unsigned SETTLE_CYCLES = 8;
  localparam int unsigned MAX_REPORTS   = 40;
  localparam int          ITEM_W        = $bits(item_t);

  // one clock reading as the result beat carries it
  typedef struct {
    logic [3:0]  hour;
    logic [5:0]  minute;
    logic [5:0]  second;
    logic        is_am;
    logic [2:0]  weekday;
    logic [4:0]  day_of_month;
    logic [3:0]  month_now;
    logic [13:0] year_now;
    logic        colon_on;
  } rtc_view_t;

  logic        clk;
  logic        rst_n     = 1'b0;
  logic        cfg_we    = 1'b0;
  logic [15:0] cfg_wdata = '0;
  logic        in_tvalid = 1'b0;
  logic        in_tready;
  // tdata: set_hour set_minute set_second set_is_am set_weekday set_date set_month set_year
  logic [47:0] in_tdata  = '0;
  // tuser: req_type
  logic        in_tuser  = REQ_TICK;
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  // tdata: hour minute second is_am weekday day_of_month month_now year_now colon_on
  logic [47:0] out_tdata;

  // clock state of the predictor; kept wide so that carries past a field width show up
  int unsigned rate_now  = TPS_RESET;
  int unsigned tick_cnt  = 0;
  int unsigned sec_now   = SEC_RESET;
  int unsigned min_now   = MIN_RESET;
  int unsigned hour_now  = HOUR_RESET;
  int unsigned am_now    = AM_RESET;
  int unsigned wday_now  = WDAY_RESET;
  int unsigned date_now  = DATE_RESET;
  int unsigned mon_now   = MONTH_RESET;
  int unsigned yr_now    = YEAR_RESET;
  int unsigned blink_now = 0;

  item_t       req_q[$];       // requests waiting for the driver
  rtc_view_t   want_q[$];      // predicted readings, oldest first
  item_t       cur_req;        // request on the input bus right now
  int unsigned send_gap   = 0;
  int unsigned send_burst = 0;
  int unsigned recv_gap   = 0;
  int unsigned recv_burst = 0;
  logic        long_hold  = 1'b0;
  int unsigned err_cnt    = 0;
  int unsigned beat_cnt   = 0;
  int unsigned cycle_cnt  = 0;

  rtc_calendar_12h_core uut (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_we     (cfg_we),
    .cfg_wdata  (cfg_wdata),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // ---------------------------------------------------------------- predictor

  // gregorian month length; anything outside 1..12 counts as february
  function automatic int unsigned days_in(input int unsigned m, input int unsigned y);
    logic leap;
    leap = (y % 4 == 0) && ((y % 100 != 0) || (y % 400 == 0));
    if (m inside {1, 3, 5, 7, 8, 10, 12}) return 31;
    if (m inside {4, 6, 9, 11}) return 30;
    return leap ? 29 : 28;
  endfunction

  // am/pm flip at 12:00:00; the calendar only moves on the flip to am,
  // but the month and year checks run on every flip
  function automatic void flip_meridiem();
    int unsigned d, w, m;
    am_now ^= 1;
    d = date_now;
    w = wday_now;
    m = mon_now;
    if (am_now == 1) begin
      d++;
      w++;
    end
    if (w > WDAY_MAX) w = WDAY_MIN;
    if (d > days_in(m, yr_now)) begin
      d = DATE_MIN;
      m++;
    end
    if (m > MONTH_MAX) begin
      m = MONTH_MIN;
      yr_now = (yr_now + 1 > YEAR_MAX) ? 0 : yr_now + 1;
    end
    date_now = d & 'h1F;
    wday_now = w & 'h7;
    mon_now  = m & 'hF;
  endfunction

  // applies one request and returns the reading the block must show after it
  function automatic rtc_view_t advance_rtc(input item_t req);
    int unsigned t;
    rtc_view_t   v;
    if (req.req_type == REQ_SET) begin
      hour_now = req.set_hour;
      min_now  = req.set_minute;
      sec_now  = req.set_second;
      am_now   = req.set_is_am;
      wday_now = req.set_weekday;
      date_now = req.set_date;
      mon_now  = req.set_month;
      yr_now   = req.set_year;
      if (date_now > days_in(mon_now, yr_now)) date_now = DATE_MIN;
      tick_cnt = 0;
    end else begin
      t = tick_cnt + 1;
      if (t >= rate_now) begin
        t = 0;
        sec_now++;
        blink_now ^= 1;
      end
      tick_cnt = t & 'hFFFF;
      // an oversized second wraps on any tick, the minute only on that carry
      if (sec_now > SEC_MAX) begin
        sec_now = 0;
        min_now++;
        if (min_now > MIN_MAX) begin
          min_now = 0;
          hour_now++;
          if (hour_now > HOUR_MAX) hour_now = HOUR_MIN;
          if (hour_now == HOUR_MAX) flip_meridiem();
        end
      end
      sec_now  &= 'h3F;
      min_now  &= 'h3F;
      hour_now &= 'hF;
    end
    v.hour         = 4'(hour_now);
    v.minute       = 6'(min_now);
    v.second       = 6'(sec_now);
    v.is_am        = 1'(am_now);
    v.weekday      = 3'(wday_now);
    v.day_of_month = 5'(date_now);
    v.month_now    = 4'(mon_now);
    v.year_now     = 14'(yr_now);
    v.colon_on     = 1'(blink_now);
    return v;
  endfunction

  // ---------------------------------------------------------------- stimulus helpers

  // idle length after a beat: mostly none or short, a few long, sometimes a burst with none
  function automatic int unsigned idle_len(inout int unsigned burst);
    int unsigned roll;
    if (burst > 0) begin
      burst--;
      return 0;
    end
    roll = $urandom_range(0, 99);
    if (roll < 4) begin
      burst = $urandom_range(20, 60);
      return 0;
    end
    if (roll < 55) return 0;
    if (roll < 85) return $urandom_range(1, 3);
    if (roll < 96) return $urandom_range(4, 12);
    return $urandom_range(20, 50);
  endfunction

  task automatic push_set(input int unsigned h, input int unsigned mi, input int unsigned s,
                          input int unsigned am, input int unsigned wd, input int unsigned d,
                          input int unsigned mo, input int unsigned y);
    item_t r;
    r.req_type    = REQ_SET;
    r.set_hour    = 4'(h);
    r.set_minute  = 6'(mi);
    r.set_second  = 6'(s);
    r.set_is_am   = 1'(am);
    r.set_weekday = 3'(wd);
    r.set_date    = 5'(d);
    r.set_month   = 4'(mo);
    r.set_year    = 14'(y);
    req_q.push_back(r);
  endtask

  // tick beats carry random junk in the set fields, which the block ignores
  task automatic push_ticks(input int unsigned n);
    item_t r;
    repeat (n) begin
      r          = item_t'(ITEM_W'({$urandom(), $urandom()}));
      r.req_type = REQ_TICK;
      req_q.push_back(r);
    end
  endtask

  // set close to a rollover: late in the hour, at month end, around leap and wrap years
  function automatic item_t boundary_set();
    item_t r;
    r.req_type = REQ_SET;
    case ($urandom_range(0, 5))
      0, 1, 2: r.set_hour = 4'd11;
      3:       r.set_hour = 4'd12;
      default: r.set_hour = 4'($urandom_range(0, 15));
    endcase
    r.set_minute  = ($urandom_range(0, 9) < 7) ? 6'd59 : 6'($urandom_range(0, 63));
    r.set_second  = 6'($urandom_range(48, 63));
    r.set_is_am   = 1'($urandom_range(0, 1));
    r.set_weekday = 3'($urandom_range(0, 7));
    case ($urandom_range(0, 5))
      0:       r.set_month = 4'd2;
      1:       r.set_month = 4'd12;
      2, 3:    r.set_month = 4'($urandom_range(1, 12));
      default: r.set_month = 4'($urandom_range(0, 15));
    endcase
    r.set_date = ($urandom_range(0, 9) < 6) ? 5'($urandom_range(28, 31))
                                            : 5'($urandom_range(0, 31));
    case ($urandom_range(0, 9))
      0:       r.set_year = 14'd1900;
      1:       r.set_year = 14'd2000;
      2:       r.set_year = 14'd2100;
      3:       r.set_year = 14'd2400;
      4:       r.set_year = 14'd2023;
      5:       r.set_year = 14'd2024;
      6:       r.set_year = 14'd9999;
      7:       r.set_year = 14'h3FFF;
      8:       r.set_year = 14'd0;
      default: r.set_year = 14'($urandom_range(0, 16383));
    endcase
    return r;
  endfunction

  // mostly a set near a rollover followed by enough ticks to cross it,
  // the rest fully random sets and plain runs of ticks
  task automatic run_phase(input int unsigned budget);
    int unsigned n, k, pick;
    item_t       r;
    n = 0;
    while (n < budget) begin
      pick = $urandom_range(0, 99);
      if (pick < 75) begin
        req_q.push_back(boundary_set());
        k = $urandom_range(1, 20);
      end else if (pick < 90) begin
        r          = item_t'(ITEM_W'({$urandom(), $urandom()}));
        r.req_type = REQ_SET;
        req_q.push_back(r);
        k = $urandom_range(0, 4);
      end else begin
        k = $urandom_range(1, 30);
        n--;
      end
      push_ticks(k);
      n += k + 1;
    end
  endtask

  // sender pause: nothing queued, nothing on the bus, every result back
  task automatic drain();
    @(negedge clk);
    while (req_q.size() != 0 || in_tvalid || want_q.size() != 0) @(negedge clk);
  endtask

  // rate change only while the block is idle; the predictor follows at once
  task automatic set_rate(input logic [15:0] value);
    drain();
    repeat (SETTLE_CYCLES) @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_wdata <= value;
    @(posedge clk);
    cfg_we    <= 1'b0;
    rate_now  = value;
    @(negedge clk);
  endtask

  task automatic flag_error(input string msg);
    err_cnt++;
    if (err_cnt <= MAX_REPORTS) $display("mismatch: %s", msg);
  endtask

  task automatic check_field(input string name, input int unsigned got,
                             input int unsigned want);
    if (got != want)
      flag_error($sformatf("beat %0d %s got %0d expected %0d", beat_cnt, name, got, want));
  endtask

  // ---------------------------------------------------------------- driver

  // predicts on acceptance, then offers the next request after its idle gap
  always @(posedge clk) begin
    if (!rst_n) begin
      in_tvalid <= 1'b0;
    end else begin
      if (in_tvalid && in_tready) want_q.push_back(advance_rtc(cur_req));
      if (!in_tvalid || in_tready) begin
        if (send_gap > 0) begin
          send_gap--;
          in_tvalid <= 1'b0;
        end else if (req_q.size() > 0) begin
          cur_req   = req_q.pop_front();
          in_tdata  <= {5'd0, cur_req.set_year, cur_req.set_month, cur_req.set_date,
                        cur_req.set_weekday, cur_req.set_is_am, cur_req.set_second,
                        cur_req.set_minute, cur_req.set_hour};
          in_tuser  <= cur_req.req_type;
          in_tvalid <= 1'b1;
          send_gap  = idle_len(send_burst);
        end else begin
          in_tvalid <= 1'b0;
        end
      end
    end
  end

  // ---------------------------------------------------------------- receiver

  // random back-pressure after result beats, plus the long hold-off on request
  always @(posedge clk) begin
    if (!rst_n) begin
      out_tready <= 1'b0;
    end else begin
      if (out_tvalid && out_tready) recv_gap = idle_len(recv_burst);
      if (long_hold) begin
        out_tready <= 1'b0;
      end else if (recv_gap > 0) begin
        recv_gap--;
        out_tready <= 1'b0;
      end else begin
        out_tready <= 1'b1;
      end
    end
  end

  // ---------------------------------------------------------------- monitor

  always @(posedge clk) begin
    rtc_view_t w;
    if (rst_n && out_tvalid && out_tready) begin
      beat_cnt++;
      if (want_q.size() == 0) begin
        flag_error($sformatf("result beat %0d with nothing expected", beat_cnt));
      end else begin
        w = want_q.pop_front();
        check_field("hour",         out_tdata[3:0],   w.hour);
        check_field("minute",       out_tdata[9:4],   w.minute);
        check_field("second",       out_tdata[15:10], w.second);
        check_field("is_am",        out_tdata[16],    w.is_am);
        check_field("weekday",      out_tdata[19:17], w.weekday);
        check_field("day_of_month", out_tdata[24:20], w.day_of_month);
        check_field("month_now",    out_tdata[28:25], w.month_now);
        check_field("year_now",     out_tdata[42:29], w.year_now);
        check_field("colon_on",     out_tdata[43],    w.colon_on);
      end
    end
  end

  // watchdog
  always @(posedge clk) begin
    cycle_cnt++;
    if (cycle_cnt > CYCLE_LIMIT) begin
      $display("end of test: mismatches");
      $finish;
    end
  end

  // ---------------------------------------------------------------- test sequence

  initial begin
    logic [15:0] phase_rate [7];
    phase_rate    = '{16'd1, 16'd0, 16'd2, 16'hFFFF, 16'd1, 16'd1, 16'd1};
    phase_rate[5] = 16'($urandom_range(3, 9));

    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // reset rate of 1000: five ticks leave the counter at 5, the second stays put
    push_ticks(5);
    // new rate below the counter: the next tick advances the second at once
    set_rate(16'd3);
    push_ticks(1);
    // second above 59 wraps on the tick; 11:59 pm on the last day of 9999 rolls to year 0
    push_set(11, 59, 63, 0, 7, 31, 12, 9999);
    push_ticks(1);
    // hour 0 and hour 15 both step to 1, minute above 59 carries
    push_set(0, 59, 59, 1, 3, 29, 2, 2000);
    push_ticks(3);
    push_set(15, 62, 59, 1, 3, 15, 6, 2001);
    push_ticks(3);

    // zero rate: every tick advances the second
    set_rate(16'd0);
    // month 13 uses the february length and rolls over, year above 9999 wraps,
    // weekday 0 steps to 1
    push_set(11, 59, 59, 0, 0, 28, 13, 16383);
    push_ticks(1);
    // flip to pm leaves the date alone
    push_set(11, 59, 59, 1, 5, 31, 1, 2024);
    push_ticks(1);
    // oversized dates forced to 1 on load: april 31, feb 29 in 1900 (kept in 2400),
    // every field at its top value, then all zero (date 0 is not forced)
    push_set(1, 0, 0, 1, 1, 31, 4, 2023);
    push_set(1, 0, 0, 1, 1, 29, 2, 1900);
    push_set(1, 0, 0, 1, 1, 29, 2, 2400);
    push_set(15, 63, 63, 1, 7, 31, 15, 16383);
    push_set(0, 0, 0, 0, 0, 0, 0, 0);
    push_ticks(1);

    // random phases, each at its rate from phase_rate; the first one also holds the receiver
    // off long enough for the block to back up and stall its input
    foreach (phase_rate[i]) begin
      set_rate(phase_rate[i]);
      run_phase(85);
      if (i == 0) begin
        @(posedge clk);
        long_hold <= 1'b1;
        repeat (HOLD_CYCLES) @(posedge clk);
        long_hold <= 1'b0;
      end
    end

    drain();
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (err_cnt == 0 && want_q.size() == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

endmodule
